@@ hw/rtl/sspsq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shared SPI priority sequencer package
// Codes, configuration, state and result types shared by the sequencer files.
// ----------------------------------------------------------------------------
package sspsq_pkg;

	// event codes carried in the input tuser
	typedef logic [2:0] action_t;
	localparam action_t ACT_POLL      = 3'd0;
	localparam action_t ACT_DAC_WORD  = 3'd1;
	localparam action_t ACT_PUSH      = 3'd2;
	localparam action_t ACT_REPLY     = 3'd3;
	localparam action_t ACT_DMA_DONE  = 3'd4;
	localparam action_t ACT_DAC_DONE  = 3'd5;

	// bus commands carried in the output tuser
	typedef logic [2:0] cmd_t;
	localparam cmd_t CMD_NONE     = 3'd0;
	localparam cmd_t CMD_DAC      = 3'd1;
	localparam cmd_t CMD_SELECT   = 3'd2;
	localparam cmd_t CMD_DESELECT = 3'd3;
	localparam cmd_t CMD_DMA      = 3'd4;

	// handshake messages
	typedef logic [1:0] msg_t;
	localparam msg_t MSG_NONE     = 2'd0;
	localparam msg_t MSG_SELECT   = 2'd1;
	localparam msg_t MSG_DESELECT = 2'd2;

	// configuration register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_RETRY_TICKS    = 2'd0;
	localparam reg_idx_t REG_WATCHDOG_TICKS = 2'd1;
	localparam reg_idx_t REG_FRAME_BYTES    = 2'd2;

	localparam logic [14:0] RETRY_TICKS_RST    = 15'd50;
	localparam logic [14:0] WATCHDOG_TICKS_RST = 15'd50;
	localparam logic [15:0] FRAME_BYTES_RST    = 16'd1024;

	typedef struct packed {
		logic [14:0] retry_ticks;
		logic [14:0] watchdog_ticks;
		logic [15:0] frame_bytes;
	} cfg_t;

	typedef struct packed {
		logic        dac_pending;
		logic [31:0] dac_data;
		logic        bus_active;
		logic        display_sending;
		logic        dac_sending;
		msg_t        awaited;
		msg_t        queued;
		msg_t        last;
		logic [15:0] retry_deadline;
		logic        wd_armed;
		logic [15:0] wd_deadline;
	} seq_state_t;

	localparam seq_state_t SEQ_STATE_RST = '{
		dac_pending:     1'b0,
		dac_data:        32'd0,
		bus_active:      1'b0,
		display_sending: 1'b0,
		dac_sending:     1'b0,
		awaited:         MSG_NONE,
		queued:          MSG_NONE,
		last:            MSG_NONE,
		retry_deadline:  16'd0,
		wd_armed:        1'b0,
		wd_deadline:     16'd0
	};

	// ring requests from the step logic
	typedef struct packed {
		logic push;
		logic pop;
	} ring_req_t;

	// ring status toward the step logic
	typedef struct packed {
		logic        empty;
		logic        full;
		logic [31:0] head;
	} ring_stat_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] command_word;
		logic [15:0] dma_length;
		logic        dac_released;
		logic        bus_busy;
		logic        push_rejected;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/sspsq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module sspsq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

@@ hw/rtl/sspsq_ring.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Frame address ring
// Circular queue of frame addresses; presents the head entry every cycle.
// ----------------------------------------------------------------------------
module sspsq_ring
	import sspsq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ring_req_t   req,
	input  wire logic [31:0] wr_data,
	output ring_stat_t       stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0] count_q;
	logic             bypass_q;
	logic [31:0]      bypass_data_q;
	logic [31:0]      ram_rd_data;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// read address follows the pointer as it will be after this cycle
	assign rd_ptr_d = req.pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;

	sspsq_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (req.push),
		.wr_addr(wr_ptr_q),
		.wr_data(wr_data),
		.rd_addr(rd_ptr_d),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			bypass_q <= 1'b0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			if (req.push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (req.push && !req.pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (req.pop && !req.push) begin
				count_q <= count_q - CNT_W'(1);
			end
			// write into the slot being read: RAM returns the old word
			bypass_q <= req.push && (wr_ptr_q == rd_ptr_d);
		end
	end

	always_ff @(posedge clk) begin
		bypass_data_q <= wr_data;
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_FULL);
	assign stat.head  = bypass_q ? bypass_data_q : ram_rd_data;

endmodule
`default_nettype wire

@@ hw/rtl/sspsq_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer step logic
// Next state, ring request and result for one event, all combinational.
// ----------------------------------------------------------------------------
module sspsq_step
	import sspsq_pkg::*;
(
	input  wire seq_state_t  st,
	input  wire cfg_t        cfg,
	input  wire ring_stat_t  ring,
	input  wire action_t     action,
	input  wire logic [15:0] now_tick,
	input  wire logic [31:0] dac_word,
	output seq_state_t       st_n,
	output ring_req_t        ring_req,
	output result_t          res
);

	logic        do_dma_done;
	logic        do_select;
	logic        send_msg;
	msg_t        msg;
	logic [15:0] retry_due;
	logic [15:0] wd_due;

	// signed 16-bit tick difference is non-negative
	function automatic logic tick_reached(input logic [15:0] now, input logic [15:0] due);
		logic [15:0] diff;
		diff = now - due;
		tick_reached = !diff[15];
	endfunction

	assign retry_due = now_tick + {1'b0, cfg.retry_ticks};
	assign wd_due    = now_tick + {1'b0, cfg.watchdog_ticks};

	always_comb begin
		st_n              = st;
		ring_req          = '0;
		res               = '0;
		res.command       = CMD_NONE;
		do_dma_done       = 1'b0;
		do_select         = 1'b0;
		send_msg          = 1'b0;
		msg               = MSG_NONE;

		case (action)
			ACT_POLL: begin
				if (st.queued != MSG_NONE) begin
					st_n.awaited = st.queued;
					st_n.queued  = MSG_NONE;
					send_msg     = 1'b1;
					msg          = st.queued;
				end else if (st.awaited != MSG_NONE) begin
					if (tick_reached(now_tick, st.retry_deadline)) begin
						send_msg = 1'b1;
						msg      = st.awaited;
					end
				end else if (st.display_sending && st.bus_active) begin
					if (!st.wd_armed) begin
						st_n.wd_armed    = 1'b1;
						st_n.wd_deadline = wd_due;
					end else if (tick_reached(now_tick, st.wd_deadline)) begin
						st_n.wd_armed = 1'b0;
						do_dma_done   = 1'b1;
					end
				end else begin
					st_n.wd_armed = 1'b0;
				end
			end
			ACT_DAC_WORD: begin
				st_n.dac_data    = dac_word;
				st_n.dac_pending = 1'b1;
				if (!st.bus_active) begin
					st_n.bus_active   = 1'b1;
					st_n.dac_pending  = 1'b0;
					st_n.dac_sending  = 1'b1;
					res.command       = CMD_DAC;
					res.command_word  = dac_word;
				end
			end
			ACT_PUSH: begin
				if (ring.full) begin
					res.push_rejected = 1'b1;
				end else begin
					ring_req.push = 1'b1;
					if (!st.bus_active) begin
						st_n.bus_active = 1'b1;
						if (st.dac_pending) begin
							st_n.dac_pending = 1'b0;
							st_n.dac_sending = 1'b1;
							res.command      = CMD_DAC;
							res.command_word = st.dac_data;
						end else begin
							st_n.display_sending = 1'b1;
							st_n.queued          = MSG_SELECT;
						end
					end
				end
			end
			ACT_REPLY: begin
				if (st.awaited == MSG_SELECT) begin
					do_select = 1'b1;
				end else if (st.awaited == MSG_DESELECT) begin
					st_n.awaited         = MSG_NONE;
					st_n.bus_active      = 1'b0;
					st_n.display_sending = 1'b0;
					if (st.dac_pending) begin
						st_n.bus_active  = 1'b1;
						st_n.dac_pending = 1'b0;
						st_n.dac_sending = 1'b1;
						res.command      = CMD_DAC;
						res.command_word = st.dac_data;
					end else if (!ring.empty) begin
						st_n.bus_active      = 1'b1;
						st_n.display_sending = 1'b1;
						st_n.queued          = MSG_SELECT;
					end
				end
			end
			ACT_DMA_DONE: begin
				if (st.display_sending && st.bus_active && st.awaited == MSG_NONE &&
				    st.queued == MSG_NONE) begin
					do_dma_done = 1'b1;
				end
			end
			ACT_DAC_DONE: begin
				if (st.dac_sending) begin
					res.dac_released = 1'b1;
					if (st.dac_pending) begin
						st_n.dac_pending = 1'b0;
						res.command      = CMD_DAC;
						res.command_word = st.dac_data;
					end else begin
						st_n.dac_sending = 1'b0;
						if (!ring.empty) begin
							st_n.display_sending = 1'b1;
							st_n.queued          = MSG_SELECT;
						end else begin
							st_n.bus_active = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase

		// DMA finished (reported or by watchdog): chain the next frame or close
		if (do_dma_done) begin
			st_n.wd_armed = 1'b0;
			if (!st.dac_pending && !ring.empty && st.last == MSG_SELECT) begin
				do_select = 1'b1;
			end else begin
				st_n.queued = MSG_DESELECT;
			end
		end

		// select acknowledged: start DMA from the ring head, or queue a deselect if the ring is empty
		if (do_select) begin
			st_n.awaited = MSG_NONE;
			if (ring.empty) begin
				st_n.queued = MSG_DESELECT;
			end else begin
				ring_req.pop     = 1'b1;
				st_n.wd_armed    = 1'b1;
				st_n.wd_deadline = wd_due;
				res.command      = CMD_DMA;
				res.command_word = ring.head;
			end
		end

		if (send_msg) begin
			st_n.last           = msg;
			st_n.retry_deadline = retry_due;
			res.command         = (msg == MSG_SELECT) ? CMD_SELECT : CMD_DESELECT;
			res.command_word    = '0;
		end

		res.dma_length = (res.command == CMD_DMA) ? cfg.frame_bytes : 16'd0;
		res.bus_busy   = st_n.bus_active;
	end

endmodule
`default_nettype wire

@@ hw/rtl/shared_spi_priority_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shared SPI priority sequencer
// Arbitrates one SPI bus between a latest-wins DAC word and queued frames.
// ----------------------------------------------------------------------------
// Usage:
//   Events (tick poll, DAC word, frame push, handshake reply, DMA done,
//   DAC done) arrive on the s_ stream, one per transaction. Every event gives
//   exactly one result transaction on the m_ stream: the bus command to issue
//   (or none), its word, the DMA length and the status flags.
//   Registers are written through cfg_wr_en / cfg_index / cfg_wdata while the
//   block is idle; a write takes effect at the clock edge it is sampled.
// Pipeline and throughput:
//   An event taken from the s_ stream is held in the input register; the step
//   logic runs from the input register straight into the result register,
//   which loads once the result slot is free. One event per cycle is sustained
//   while m_tready stays high; the limit is the single step stage that owns all
//   sequencer state.
// Reset:
//   arst_n clears the bus state, empties the frame ring and loads the register
//   defaults (retry 50 ticks, watchdog 50 ticks, 1024-byte frames).
// Stall:
//   When m_tready is low the result holds, one further event waits in the
//   input register, and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module shared_spi_priority_sequencer
	import sspsq_pkg::*;
#(
	parameter int RING_DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// event stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // now_tick[15:0], dac_word[47:16], frame_address[79:48]
	input  wire logic [2:0]  s_tuser,   // action[2:0]
	// command stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // command_word[31:0], dma_length[47:32],
	                                    // dac_released[48], bus_busy[49], push_rejected[50], zero
	output logic [2:0]       m_tuser,   // command[2:0]
	// configuration write port
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	// input register
	logic        valid_s1;
	action_t     action_s1;
	logic [15:0] now_tick_s1;
	logic [31:0] dac_word_s1;
	logic [31:0] frame_address_s1;

	// result register
	logic        out_valid_q;
	result_t     result_q;

	cfg_t        cfg_q;
	seq_state_t  state_q, state_d;
	ring_req_t   ring_req;
	ring_stat_t  ring_stat;
	result_t     result_d;
	logic        advance;

	// Advance the step stage when it holds an event and the result slot frees.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1        <= s_tuser;
			now_tick_s1      <= s_tdata[15:0];
			dac_word_s1      <= s_tdata[47:16];
			frame_address_s1 <= s_tdata[79:48];
		end
	end

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_ticks    <= RETRY_TICKS_RST;
			cfg_q.watchdog_ticks <= WATCHDOG_TICKS_RST;
			cfg_q.frame_bytes    <= FRAME_BYTES_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RETRY_TICKS:    cfg_q.retry_ticks    <= cfg_wdata[14:0];
				REG_WATCHDOG_TICKS: cfg_q.watchdog_ticks <= cfg_wdata[14:0];
				REG_FRAME_BYTES:    cfg_q.frame_bytes    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	sspsq_step u_step (
		.st      (state_q),
		.cfg     (cfg_q),
		.ring    (ring_stat),
		.action  (action_s1),
		.now_tick(now_tick_s1),
		.dac_word(dac_word_s1),
		.st_n    (state_d),
		.ring_req(ring_req),
		.res     (result_d)
	);

	// Ring only moves on the cycle its event is committed.
	ring_req_t ring_req_gated;
	assign ring_req_gated.push = ring_req.push && advance;
	assign ring_req_gated.pop  = ring_req.pop && advance;

	sspsq_ring #(
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ring_req_gated),
		.wr_data(frame_address_s1),
		.stat   (ring_stat)
	);

	// Commit sequencer state with the event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_STATE_RST;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// Result register: load on advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = result_q.command;
	assign m_tdata  = {5'd0, result_q.push_rejected, result_q.bus_busy,
	                   result_q.dac_released, result_q.dma_length, result_q.command_word};

endmodule
`default_nettype wire

@@ sim/shared_spi_priority_sequencer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shared SPI priority sequencer testbench
// Drives bus and timer events into the sequencer, predicts every command
// in a cycle-free model of the arbitration and compares each result field by
// field. Traffic follows the command the sequencer just issued, with random
// noise, stalls on both streams and several register settings.
// ----------------------------------------------------------------------------
module shared_spi_priority_sequencer_tb;
	import sspsq_pkg::*;

	localparam int RING_DEPTH  = 8;
	localparam int RING_PTR_W  = $clog2(RING_DEPTH);
	localparam int HOLD_CYCLES = 200;
	localparam int MAX_REPORTS = 40;

	// actions with no meaning; the sequencer must ignore them
	localparam action_t ACT_RESERVED_LO = 3'd6;
	localparam action_t ACT_RESERVED_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // now_tick[15:0], dac_word[47:16], frame_address[79:48]
	logic [2:0]  s_tuser;   // action[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // command_word[31:0], dma_length[47:32], dac_released[48],
	                        // bus_busy[49], push_rejected[50], zero
	logic [2:0]  m_tuser;   // command[2:0]
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	// register copies as the sequencer should hold them
	logic [14:0] cfg_retry       = RETRY_TICKS_RST;
	logic [14:0] cfg_watchdog    = WATCHDOG_TICKS_RST;
	logic [15:0] cfg_frame_bytes = FRAME_BYTES_RST;

	// arbitration state, tracked at every accepted event
	bit          dac_pending     = 1'b0;
	logic [31:0] dac_data        = '0;
	bit          bus_active      = 1'b0;
	bit          display_sending = 1'b0;
	bit          dac_sending     = 1'b0;
	msg_t        awaited_msg     = MSG_NONE;
	msg_t        queued_msg      = MSG_NONE;
	msg_t        last_msg        = MSG_NONE;
	logic [15:0] retry_deadline  = '0;
	bit          wd_armed        = 1'b0;
	logic [15:0] wd_deadline     = '0;
	logic [31:0] frame_addrs [RING_DEPTH];
	logic [RING_PTR_W-1:0] ring_rd = '0;
	logic [RING_PTR_W-1:0] ring_wr = '0;
	int unsigned ring_fill       = 0;

	// command built up during one event
	cmd_t        out_cmd;
	logic [31:0] out_word;
	logic [15:0] out_len;

	result_t     predicted_commands [$];
	logic [15:0] slow_tick       = '0;
	bit          idle_bursts_on  = 1'b0;
	bit          hold_go         = 1'b0;
	bit          sink_hold       = 1'b0;
	int          mismatches      = 0;
	int          events_sent     = 0;
	int          results_seen    = 0;
	int          dma_seen        = 0;
	int          dac_seen        = 0;
	int          rejects_seen    = 0;
	int          settings_used   = 1;

	shared_spi_priority_sequencer #(
		.RING_DEPTH(RING_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Command prediction
	// ------------------------------------------------------------------------

	// late once the signed 16-bit distance from the deadline is not negative
	function automatic bit deadline_reached(logic [15:0] now, logic [15:0] deadline);
		logic [15:0] diff;
		diff = now - deadline;
		return ~diff[15];
	endfunction

	function automatic logic [RING_PTR_W-1:0] ring_next(logic [RING_PTR_W-1:0] p);
		return (int'(p) == RING_DEPTH - 1) ? '0 : p + RING_PTR_W'(1);
	endfunction

	function automatic void issue(cmd_t cmd, logic [31:0] word);
		out_cmd  = cmd;
		out_word = word;
		out_len  = (cmd == CMD_DMA) ? cfg_frame_bytes : 16'd0;
	endfunction

	// a waiting DAC word always wins the bus
	function automatic bit flush_dac();
		if (!dac_pending)
			return 1'b0;
		dac_pending = 1'b0;
		dac_sending = 1'b1;
		issue(CMD_DAC, dac_data);
		return 1'b1;
	endfunction

	function automatic void begin_frames();
		bus_active = 1'b1;
		if (flush_dac())
			return;
		display_sending = 1'b1;
		queued_msg      = MSG_SELECT;
	endfunction

	// select answered: pop the next frame and start its DMA
	function automatic void finish_select(logic [15:0] now);
		logic [31:0] head;
		awaited_msg = MSG_NONE;
		if (ring_fill == 0) begin
			queued_msg = MSG_DESELECT;
			return;
		end
		head      = frame_addrs[ring_rd];
		ring_rd   = ring_next(ring_rd);
		ring_fill = ring_fill - 1;
		wd_armed    = 1'b1;
		wd_deadline = now + {1'b0, cfg_watchdog};
		issue(CMD_DMA, head);
	endfunction

	function automatic void finish_deselect();
		awaited_msg     = MSG_NONE;
		bus_active      = 1'b0;
		display_sending = 1'b0;
		if (dac_pending) begin
			bus_active = 1'b1;
			void'(flush_dac());
			return;
		end
		if (ring_fill != 0)
			begin_frames();
	endfunction

	// chain straight into the next frame while the display stays selected and no DAC word waits, else queue a deselect
	function automatic void finish_dma(logic [15:0] now);
		wd_armed = 1'b0;
		if (!dac_pending && ring_fill != 0 && last_msg == MSG_SELECT)
			finish_select(now);
		else
			queued_msg = MSG_DESELECT;
	endfunction

	function automatic bit dma_busy();
		return display_sending && bus_active && awaited_msg == MSG_NONE &&
			queued_msg == MSG_NONE;
	endfunction

	function automatic void send_message(logic [15:0] now);
		last_msg       = awaited_msg;
		retry_deadline = now + {1'b0, cfg_retry};
		issue(awaited_msg == MSG_SELECT ? CMD_SELECT : CMD_DESELECT, 32'd0);
	endfunction

	function automatic void poll_timers(logic [15:0] now);
		if (queued_msg != MSG_NONE) begin
			awaited_msg = queued_msg;
			queued_msg  = MSG_NONE;
			send_message(now);
		end else if (awaited_msg != MSG_NONE) begin
			if (deadline_reached(now, retry_deadline))
				send_message(now);
		end else if (display_sending && bus_active) begin
			if (!wd_armed) begin
				wd_armed    = 1'b1;
				wd_deadline = now + {1'b0, cfg_watchdog};
			end else if (deadline_reached(now, wd_deadline)) begin
				wd_armed = 1'b0;
				finish_dma(now);
			end
		end else begin
			wd_armed = 1'b0;
		end
	endfunction

	// advance the arbitration by one event and return the command it gives
	function automatic result_t sequence_event(action_t act, logic [15:0] now,
			logic [31:0] word, logic [31:0] addr);
		result_t r;
		bit      released;
		bit      rejected;
		released = 1'b0;
		rejected = 1'b0;
		issue(CMD_NONE, 32'd0);
		case (act)
			ACT_POLL: begin
				poll_timers(now);
			end
			ACT_DAC_WORD: begin
				dac_data    = word;
				dac_pending = 1'b1;
				if (!bus_active) begin
					bus_active = 1'b1;
					void'(flush_dac());
				end
			end
			ACT_PUSH: begin
				if (ring_fill >= RING_DEPTH) begin
					rejected = 1'b1;
				end else begin
					frame_addrs[ring_wr] = addr;
					ring_wr   = ring_next(ring_wr);
					ring_fill = ring_fill + 1;
					if (!bus_active)
						begin_frames();
				end
			end
			ACT_REPLY: begin
				if (awaited_msg == MSG_SELECT)
					finish_select(now);
				else if (awaited_msg == MSG_DESELECT)
					finish_deselect();
			end
			ACT_DMA_DONE: begin
				if (dma_busy())
					finish_dma(now);
			end
			ACT_DAC_DONE: begin
				if (dac_sending) begin
					released = 1'b1;
					if (!flush_dac()) begin
						dac_sending = 1'b0;
						if (ring_fill != 0) begin
							display_sending = 1'b1;
							queued_msg      = MSG_SELECT;
						end else begin
							bus_active = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
		r.command       = out_cmd;
		r.command_word  = out_word;
		r.dma_length    = out_len;
		r.dac_released  = released;
		r.bus_busy      = bus_active;
		r.push_rejected = rejected;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: mismatch on %s at result %0d: got %h, expected %h",
				$realtime, what, results_seen, got, want);
	endtask

	// compare every result transaction against the oldest prediction
	always @(posedge clk) begin : check_commands
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.command       = m_tuser;
			got.command_word  = m_tdata[31:0];
			got.dma_length    = m_tdata[47:32];
			got.dac_released  = m_tdata[48];
			got.bus_busy      = m_tdata[49];
			got.push_rejected = m_tdata[50];
			if (predicted_commands.size() == 0) begin
				report_mismatch("unexpected result", got.command_word, 32'd0);
			end else begin
				want = predicted_commands.pop_front();
				if (got.command != want.command)
					report_mismatch("command", 32'(got.command), 32'(want.command));
				if (got.command_word != want.command_word)
					report_mismatch("command_word", got.command_word, want.command_word);
				if (got.dma_length != want.dma_length)
					report_mismatch("dma_length", 32'(got.dma_length),
						32'(want.dma_length));
				if (got.dac_released != want.dac_released)
					report_mismatch("dac_released", 32'(got.dac_released),
						32'(want.dac_released));
				if (got.bus_busy != want.bus_busy)
					report_mismatch("bus_busy", 32'(got.bus_busy), 32'(want.bus_busy));
				if (got.push_rejected != want.push_rejected)
					report_mismatch("push_rejected", 32'(got.push_rejected),
						32'(want.push_rejected));
				if (want.command == CMD_DMA)
					dma_seen++;
				if (want.command == CMD_DAC)
					dac_seen++;
				if (want.push_rejected)
					rejects_seen++;
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver side
	// ------------------------------------------------------------------------

	// long hold-off, counted on rising edges so the ready driver sees a settled flag
	initial begin : hold_off_receiver
		forever begin
			wait (hold_go);
			@(posedge clk);
			sink_hold = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			sink_hold = 1'b0;
			hold_go   = 1'b0;
		end
	end

	// random stall bursts while idling is on
	initial begin : drive_command_ready
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold) begin
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_bursts_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender side and register access
	// ------------------------------------------------------------------------

	// offer one event from a falling edge, predict it once the transaction is taken
	task automatic send_event(action_t act, logic [15:0] now, logic [31:0] word,
			logic [31:0] addr);
		int gap;
		if (idle_bursts_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {addr, word, now};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted_commands.push_back(sequence_event(act, now, word, addr));
		events_sent++;
		@(negedge clk);
	endtask

	// drop valid and let every outstanding command come back
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (predicted_commands.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_RETRY_TICKS:    cfg_retry       = value[14:0];
			REG_WATCHDOG_TICKS: cfg_watchdog    = value[14:0];
			REG_FRAME_BYTES:    cfg_frame_bytes = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_settings(logic [14:0] retry, logic [14:0] watchdog,
			logic [15:0] bytes);
		wait_drain();
		write_reg(REG_RETRY_TICKS, {1'b0, retry});
		write_reg(REG_WATCHDOG_TICKS, {1'b0, watchdog});
		write_reg(REG_FRAME_BYTES, bytes);
		settings_used++;
	endtask

	// mostly follow up on the command just issued, sometimes anything at all
	function automatic action_t pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return action_t'($urandom_range(0, 7));
		if (queued_msg != MSG_NONE && r < 70)
			return ACT_POLL;
		if (awaited_msg != MSG_NONE && r < 55)
			return ACT_REPLY;
		if (awaited_msg != MSG_NONE && r < 75)
			return ACT_POLL;
		if (dac_sending && r < 50)
			return ACT_DAC_DONE;
		if (dma_busy() && r < 45)
			return ACT_DMA_DONE;
		if (dma_busy() && r < 60)
			return ACT_POLL;
		r = $urandom_range(0, 99);
		if (r < 30)
			return ACT_PUSH;
		if (r < 42)
			return ACT_DAC_WORD;
		return ACT_POLL;
	endfunction

	// random traffic; the tick mostly creeps and now and then jumps far
	task automatic drive_traffic(int count);
		action_t act;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 15) == 0)
				slow_tick += 16'($urandom);
			else
				slow_tick += 16'($urandom_range(0, 24));
			act = pick_action();
			send_event(act, slow_tick, $urandom, $urandom);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// events that find nothing to act on, and the undefined action codes
	task automatic test_idle_events();
		send_event(ACT_REPLY, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_event(ACT_DMA_DONE, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_event(ACT_DAC_DONE, 16'h8000, $urandom, $urandom);
		send_event(ACT_RESERVED_LO, 16'h7FFF, $urandom, $urandom);
		send_event(ACT_RESERVED_HI, slow_tick, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// latest DAC word wins, and a done hands the bus to the waiting word
	task automatic test_dac_slot();
		send_event(ACT_DAC_WORD, slow_tick, 32'hFFFF_FFFF, $urandom);
		send_event(ACT_DAC_WORD, slow_tick, 32'h0000_0000, $urandom);
		send_event(ACT_DAC_WORD, slow_tick, 32'h1234_5678, $urandom);
		send_event(ACT_DAC_DONE, slow_tick, $urandom, $urandom);
		send_event(ACT_DAC_DONE, slow_tick, $urandom, $urandom);
	endtask

	// one frame end to end: retry of the select, full ring, DAC taking over
	task automatic test_frame_handshake();
		send_event(ACT_PUSH, slow_tick, $urandom, 32'h0000_0000);
		send_event(ACT_POLL, slow_tick, $urandom, $urandom);
		slow_tick += 16'd60;
		send_event(ACT_POLL, slow_tick, $urandom, $urandom);
		send_event(ACT_REPLY, slow_tick, $urandom, $urandom);
		send_event(ACT_PUSH, slow_tick, $urandom, 32'hFFFF_FFFF);
		repeat (RING_DEPTH)
			send_event(ACT_PUSH, slow_tick, $urandom, $urandom);
		send_event(ACT_DAC_WORD, slow_tick, 32'hA5A5_5A5A, $urandom);
		send_event(ACT_DMA_DONE, slow_tick, $urandom, $urandom);
		send_event(ACT_POLL, slow_tick, $urandom, $urandom);
		send_event(ACT_REPLY, slow_tick, $urandom, $urandom);
		wait_drain();
	endtask

	task automatic test_reset_settings();
		idle_bursts_on = 1'b1;
		drive_traffic(300);
	endtask

	task automatic test_fast_timeouts();
		apply_settings(15'd1, 15'd1, 16'hFFFF);
		drive_traffic(300);
	endtask

	task automatic test_slow_timeouts();
		apply_settings(15'h7FFF, 15'h7FFF, 16'd1);
		drive_traffic(300);
	endtask

	// zero ticks put the deadline on the current tick
	task automatic test_zero_timeouts();
		apply_settings(15'd0, 15'd0, 16'($urandom_range(1, 65535)));
		drive_traffic(250);
	endtask

	// block the receiver while events keep coming so the input side stalls
	task automatic test_backpressure();
		apply_settings(15'd50, 15'd50, 16'd1024);
		hold_go = 1'b1;
		wait (sink_hold);
		@(negedge clk);
		drive_traffic(40);
	endtask

	task automatic test_random_settings();
		repeat (3) begin
			apply_settings(15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)),
				16'($urandom_range(1, 65535)));
			drive_traffic(150);
		end
	endtask

	task automatic test_steady_stream();
		wait_drain();
		idle_bursts_on = 1'b0;
		drive_traffic(200);
	endtask

	initial begin : run_tests
		result_t lost;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = ACT_POLL;
		cfg_wr_en = 1'b0;
		cfg_index = REG_RETRY_TICKS;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_events();
		test_dac_slot();
		test_frame_handshake();
		test_reset_settings();
		test_fast_timeouts();
		test_slow_timeouts();
		test_zero_timeouts();
		test_backpressure();
		test_random_settings();
		test_steady_stream();

		// final drain, bounded
		s_tvalid <= 1'b0;
		for (int n = 0; n < 2000 && predicted_commands.size() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		while (predicted_commands.size() != 0) begin
			lost = predicted_commands.pop_front();
			report_mismatch("missing result", 32'd0, lost.command_word);
		end

		$display("Covered %0d events and %0d commands over %0d register settings:",
			events_sent, results_seen, settings_used);
		$display("  %0d DMA starts, %0d DAC words sent, %0d frame pushes refused.",
			dma_seen, dac_seen, rejects_seen);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin : run_limit
		#3_000_000;
		$display("Timed out with %0d commands still awaited", predicted_commands.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ shared_spi_priority_sequencer.f @@
hw/rtl/sspsq_pkg.sv
hw/rtl/sspsq_ram.sv
hw/rtl/sspsq_ring.sv
hw/rtl/sspsq_step.sv
hw/rtl/shared_spi_priority_sequencer.sv
sim/shared_spi_priority_sequencer_tb.sv
